/* sv/assert_macros.svh */
// assertion macros used by the quaternion to euler angles unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/qte_pkg.sv */
// constants and tables for the quaternion to euler angle converter
`default_nettype none
package qte_pkg;

   localparam int ZW          = 26;
   localparam int UW          = 31;
   localparam int SQW         = 64;
   localparam int SQRT_STEPS  = 32;
   localparam int ROLL_W      = 16;
   localparam int PITCH_W     = 15;
   localparam int OUT_180     = 23040;
   localparam int OUT_90      = 11520;
   localparam int ANG_90      = 2949120;

   // atan(2^-i) in 2^-15 degree
   localparam logic [21:0] ATAN_TABLE [32] = '{
      22'd1474560, 22'd870484, 22'd459940, 22'd233473,
      22'd117189,  22'd58652,  22'd29333,  22'd14667,
      22'd7334,    22'd3667,   22'd1833,   22'd917,
      22'd458,     22'd229,    22'd115,    22'd57,
      22'd29,      22'd14,     22'd7,      22'd4,
      22'd2,       22'd1,      22'd0,      22'd0,
      22'd0,       22'd0,      22'd0,      22'd0,
      22'd0,       22'd0,      22'd0,      22'd0
   };

endpackage
`default_nettype wire

/* sv/qte_cordic.sv */
// pipelined vectoring cordic giving a rounded and clamped atan2
`default_nettype none
module qte_cordic
   import qte_pkg::*;
#(
   parameter int WIDTH = 34,
   parameter int STEPS = 16,
   parameter int LIMIT = 23040,
   parameter int OUT_W = 16
) (
   input  wire logic                    clock,
   input  wire logic                    enable,
   input  wire logic signed [WIDTH-1:0] y_in,
   input  wire logic signed [WIDTH-1:0] x_in,
   output logic signed [OUT_W-1:0]      angle_out
);

   localparam logic signed [ZW-1:0] LIM = ZW'(LIMIT);

   logic signed [WIDTH-1:0] x_ff [0:STEPS];
   logic signed [WIDTH-1:0] y_ff [0:STEPS];
   logic signed [ZW-1:0]    z_ff [0:STEPS];
   logic                    nil_ff [0:STEPS];
   logic signed [WIDTH-1:0] x_in_a [1:STEPS];
   logic signed [WIDTH-1:0] y_in_a [1:STEPS];
   logic signed [ZW-1:0]    z_in_a [1:STEPS];
   logic signed [WIDTH-1:0] x0_in, y0_in;
   logic signed [ZW-1:0]    z0_in;
   logic signed [ZW-1:0]    r_in, rc_in;
   logic signed [OUT_W-1:0] angle_ff;

   // quadrant pre-rotation
   always_comb begin
      x0_in = x_in;
      y0_in = y_in;
      z0_in = '0;
      if (x_in < 0) begin
         if (y_in >= 0) begin
            x0_in = y_in;
            y0_in = -x_in;
            z0_in = ZW'(ANG_90);
         end else begin
            x0_in = -y_in;
            y0_in = x_in;
            z0_in = -ZW'(ANG_90);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         if (y_ff[k] > 0) begin
            x_in_a[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in_a[k+1] = y_ff[k] - (x_ff[k] >>> k);
            z_in_a[k+1] = z_ff[k] + $signed(ZW'(ATAN_TABLE[k]));
         end else begin
            x_in_a[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in_a[k+1] = y_ff[k] + (x_ff[k] >>> k);
            z_in_a[k+1] = z_ff[k] - $signed(ZW'(ATAN_TABLE[k]));
         end
      end
   end

   always_comb begin
      r_in = (z_ff[STEPS] + ZW'(128)) >>> 8;
      if (nil_ff[STEPS]) begin
         rc_in = '0;
      end else if (r_in > LIM) begin
         rc_in = LIM;
      end else if (r_in < -LIM) begin
         rc_in = -LIM;
      end else begin
         rc_in = r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]   <= x0_in;
         y_ff[0]   <= y0_in;
         z_ff[0]   <= z0_in;
         nil_ff[0] <= (x_in == 0) && (y_in == 0);
         for (int k = 1; k <= STEPS; k++) begin
            x_ff[k]   <= x_in_a[k];
            y_ff[k]   <= y_in_a[k];
            z_ff[k]   <= z_in_a[k];
            nil_ff[k] <= nil_ff[k-1];
         end
         angle_ff <= OUT_W'(rc_in);
      end
   end

   assign angle_out = angle_ff;

endmodule
`default_nettype wire

/* sv/quaternion_to_euler_angles_unit.sv */
// quaternion to zyx euler angles, fully pipelined
// throughput: one transaction per cycle; a stalled result freezes the whole pipeline
// the depth is set by the 32-stage square root for pitch and the cordic stages
// reset clears only the valid bits; no memories, no clearing pass
`default_nettype none
`include "assert_macros.svh"
module quaternion_to_euler_angles_unit
   import qte_pkg::*;
#(
   parameter int COMPONENT_WIDTH = 16,
   parameter int CORDIC_STEPS    = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   // quat_w, quat_x, quat_y, quat_z
   input  wire logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]    req_tdata,
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // roll_angle, pitch_angle, yaw_angle
   output logic [47:0]                                    rsp_tdata,
   // pitch_saturated, zero_norm
   output logic [1:0]                                     rsp_tuser
);

   localparam int CW   = COMPONENT_WIDTH;
   localparam int E    = (CW > 28) ? 28 : CW;
   localparam int RS   = CW - E;
   localparam int PW   = 2 * E;
   localparam int SUMW = 2 * E + 3;
   localparam int NW   = 2 * E + 1;
   localparam int CORW = (2 * E + 4 > 34) ? 2 * E + 4 : 34;
   localparam int SW   = $clog2(NW + 1);
   localparam int DLY  = 4 + SQRT_STEPS;
   localparam int FL   = DLY + CORDIC_STEPS + 2;
   localparam int LAT  = FL + 4;

   logic            en;
   logic [LAT-1:0]  vld_ff;

   // stage 1
   logic signed [CW-1:0] w_s, x_s, y_s, z_s;
   logic signed [E-1:0]  w1_ff, x1_ff, y1_ff, z1_ff;
   // stage 2
   logic signed [PW-1:0] ww2_ff, xx2_ff, yy2_ff, zz2_ff;
   logic signed [PW-1:0] wx2_ff, yz2_ff, wz2_ff, xy2_ff, wy2_ff, zx2_ff;
   // stage 3
   logic signed [SUMW-1:0] n_s, a_s, rnum_s, rden_s, ynum_s, yden_s;
   logic [NW-1:0]          n3_in, ua3_in;
   logic                   zero3_in, sat3_in;
   logic [NW-1:0]          n3_ff, ua3_ff;
   logic signed [CORW-1:0] rnum3_ff, rden3_ff, ynum3_ff, yden3_ff;
   logic                   neg3_ff, zero3_ff, sat3_ff;
   // stage 4 and 5
   logic [SW-1:0]          sh4_in, sh4_ff;
   logic [NW-1:0]          n4_ff, ua4_ff;
   logic [UW-1:0]          nn5_ff, us5_ff;
   // stage 6
   logic [2*UW-1:0]        p6_ff, q6_ff;
   logic [UW-1:0]          us6_ff;
   // square root
   logic [SQW-1:0]         rem_ff  [0:SQRT_STEPS];
   logic [SQW-1:0]         root_ff [0:SQRT_STEPS];
   logic [UW-1:0]          usq_ff  [0:SQRT_STEPS];
   logic [SQW-1:0]         rem_in  [1:SQRT_STEPS];
   logic [SQW-1:0]         root_in [1:SQRT_STEPS];
   // side lines
   logic signed [CORW-1:0] rnum_d [0:DLY-1];
   logic signed [CORW-1:0] rden_d [0:DLY-1];
   logic signed [CORW-1:0] ynum_d [0:DLY-1];
   logic signed [CORW-1:0] yden_d [0:DLY-1];
   logic                   zero_d [0:FL-1];
   logic                   sat_d  [0:FL-1];
   logic                   neg_d  [0:FL-1];
   // cordic
   logic signed [CORW-1:0]    py_in, px_in;
   logic signed [ROLL_W-1:0]  roll_c, yaw_c;
   logic signed [PITCH_W-1:0] pitch_c;
   // output
   logic signed [ROLL_W-1:0]  roll_in, yaw_in, roll_ff, yaw_ff;
   logic signed [PITCH_W-1:0] pitch_in, pitch_ff;
   logic                      sat_ff, zero_ff;

   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   assign w_s = $signed(req_tdata[CW-1:0]) >>> RS;
   assign x_s = $signed(req_tdata[2*CW-1:CW]) >>> RS;
   assign y_s = $signed(req_tdata[3*CW-1:2*CW]) >>> RS;
   assign z_s = $signed(req_tdata[4*CW-1:3*CW]) >>> RS;

   always_comb begin
      n_s    = SUMW'(ww2_ff) + SUMW'(xx2_ff) + SUMW'(yy2_ff) + SUMW'(zz2_ff);
      a_s    = (SUMW'(wy2_ff) - SUMW'(zx2_ff)) <<< 1;
      rnum_s = (SUMW'(wx2_ff) + SUMW'(yz2_ff)) <<< 1;
      rden_s = n_s - ((SUMW'(xx2_ff) + SUMW'(yy2_ff)) <<< 1);
      ynum_s = (SUMW'(wz2_ff) + SUMW'(xy2_ff)) <<< 1;
      yden_s = n_s - ((SUMW'(yy2_ff) + SUMW'(zz2_ff)) <<< 1);
      n3_in    = NW'(n_s);
      ua3_in   = a_s[SUMW-1] ? NW'(-a_s) : NW'(a_s);
      zero3_in = (n_s == 0);
      sat3_in  = !zero3_in && (ua3_in >= n3_in);
   end

   // shift that brings the norm below 2^31
   always_comb begin
      sh4_in = '0;
      for (int j = UW; j < NW; j++) begin
         if (n3_ff[j]) begin
            sh4_in = SW'(j - UW + 1);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (rem_ff[k] >= root_ff[k] + (SQW'(1) << (2 * (SQRT_STEPS - 1 - k)))) begin
            rem_in[k+1]  = rem_ff[k] - (root_ff[k] + (SQW'(1) << (2 * (SQRT_STEPS - 1 - k))));
            root_in[k+1] = (root_ff[k] >> 1) + (SQW'(1) << (2 * (SQRT_STEPS - 1 - k)));
         end else begin
            rem_in[k+1]  = rem_ff[k];
            root_in[k+1] = root_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff <= w_s[E-1:0];
         x1_ff <= x_s[E-1:0];
         y1_ff <= y_s[E-1:0];
         z1_ff <= z_s[E-1:0];

         ww2_ff <= w1_ff * w1_ff;
         xx2_ff <= x1_ff * x1_ff;
         yy2_ff <= y1_ff * y1_ff;
         zz2_ff <= z1_ff * z1_ff;
         wx2_ff <= w1_ff * x1_ff;
         yz2_ff <= y1_ff * z1_ff;
         wz2_ff <= w1_ff * z1_ff;
         xy2_ff <= x1_ff * y1_ff;
         wy2_ff <= w1_ff * y1_ff;
         zx2_ff <= z1_ff * x1_ff;

         n3_ff    <= n3_in;
         ua3_ff   <= ua3_in;
         rnum3_ff <= CORW'(rnum_s);
         rden3_ff <= CORW'(rden_s);
         ynum3_ff <= CORW'(ynum_s);
         yden3_ff <= CORW'(yden_s);
         neg3_ff  <= a_s[SUMW-1];
         zero3_ff <= zero3_in;
         sat3_ff  <= sat3_in;

         sh4_ff <= sh4_in;
         n4_ff  <= n3_ff;
         ua4_ff <= ua3_ff;

         nn5_ff <= UW'(n4_ff >> sh4_ff);
         us5_ff <= UW'(ua4_ff >> sh4_ff);

         p6_ff  <= nn5_ff * nn5_ff;
         q6_ff  <= us5_ff * us5_ff;
         us6_ff <= us5_ff;

         rem_ff[0]  <= SQW'(p6_ff - q6_ff);
         root_ff[0] <= '0;
         usq_ff[0]  <= us6_ff;
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            usq_ff[k]  <= usq_ff[k-1];
         end

         rnum_d[0] <= rnum3_ff;
         rden_d[0] <= rden3_ff;
         ynum_d[0] <= ynum3_ff;
         yden_d[0] <= yden3_ff;
         for (int k = 1; k < DLY; k++) begin
            rnum_d[k] <= rnum_d[k-1];
            rden_d[k] <= rden_d[k-1];
            ynum_d[k] <= ynum_d[k-1];
            yden_d[k] <= yden_d[k-1];
         end

         zero_d[0] <= zero3_ff;
         sat_d[0]  <= sat3_ff;
         neg_d[0]  <= neg3_ff;
         for (int k = 1; k < FL; k++) begin
            zero_d[k] <= zero_d[k-1];
            sat_d[k]  <= sat_d[k-1];
            neg_d[k]  <= neg_d[k-1];
         end

         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
         sat_ff   <= sat_d[FL-1];
         zero_ff  <= zero_d[FL-1];
      end
   end

   assign px_in = $signed(CORW'(root_ff[SQRT_STEPS]));
   assign py_in = neg_d[DLY-1] ? -$signed({{(CORW-UW){1'b0}}, usq_ff[SQRT_STEPS]})
                               :  $signed({{(CORW-UW){1'b0}}, usq_ff[SQRT_STEPS]});

   qte_cordic #(
      .WIDTH (CORW),
      .STEPS (CORDIC_STEPS),
      .LIMIT (OUT_180),
      .OUT_W (ROLL_W)
   ) u_roll (
      .clock     (clock),
      .enable    (en),
      .y_in      (rnum_d[DLY-1]),
      .x_in      (rden_d[DLY-1]),
      .angle_out (roll_c)
   );

   qte_cordic #(
      .WIDTH (CORW),
      .STEPS (CORDIC_STEPS),
      .LIMIT (OUT_90),
      .OUT_W (PITCH_W)
   ) u_pitch (
      .clock     (clock),
      .enable    (en),
      .y_in      (py_in),
      .x_in      (px_in),
      .angle_out (pitch_c)
   );

   qte_cordic #(
      .WIDTH (CORW),
      .STEPS (CORDIC_STEPS),
      .LIMIT (OUT_180),
      .OUT_W (ROLL_W)
   ) u_yaw (
      .clock     (clock),
      .enable    (en),
      .y_in      (ynum_d[DLY-1]),
      .x_in      (yden_d[DLY-1]),
      .angle_out (yaw_c)
   );

   always_comb begin
      roll_in  = roll_c;
      yaw_in   = yaw_c;
      pitch_in = pitch_c;
      if (zero_d[FL-1]) begin
         roll_in  = '0;
         yaw_in   = '0;
         pitch_in = '0;
      end else if (sat_d[FL-1]) begin
         pitch_in = neg_d[FL-1] ? -PITCH_W'(OUT_90) : PITCH_W'(OUT_90);
      end
   end

   assign rsp_tdata = {1'b0, yaw_ff, pitch_ff, roll_ff};
   assign rsp_tuser = {zero_ff, sat_ff};

   `ASSERT_IMPLIES(a_zero_angles, clock, reset, rsp_tvalid && zero_ff,
      (rsp_tdata[46:0] == 47'd0) && !sat_ff, "zero norm with nonzero angles")
   `ASSERT_IMPLIES(a_sat_pitch, clock, reset, rsp_tvalid && sat_ff,
      (pitch_ff == PITCH_W'(OUT_90)) || (pitch_ff == -PITCH_W'(OUT_90)),
      "saturated pitch not at limit")
   `ASSERT_IMPLIES(a_roll_range, clock, reset, rsp_tvalid,
      (roll_ff <= ROLL_W'(OUT_180)) && (roll_ff >= -ROLL_W'(OUT_180)), "roll out of range")
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

endmodule
`default_nettype wire
